@@ rtl/vn_pkg.sv @@
// Shared widths, register indexes and the queue word type for the vector normaliser.
package vn_pkg;

   localparam int NUM_LANES = 4;
   localparam int COMP_W    = 16;
   localparam int SQ_W      = 32;
   localparam int SUM_W     = 33;
   localparam int LEN_W     = 17;
   localparam int DIM_W     = 3;
   localparam int EPS_W     = 8;
   localparam int CSR_W     = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [DIM_W-1:0] DIM_MIN = 3'd2;
   localparam logic [DIM_W-1:0] DIM_MAX = 3'd4;
   localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;
   localparam logic [EPS_W-1:0] EPS_RESET = 8'd1;

   localparam logic [CSR_IDX_W-1:0] CSR_DIMENSION = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON   = 1'd1;

   // root bits, quotient bits and the Q1.14 unit
   localparam int ROOT_STAGES = 17;
   localparam int QUOT_BITS   = 15;
   localparam logic [QUOT_BITS-1:0] ONE_Q14 = 15'd16384;

   typedef logic [NUM_LANES-1:0][COMP_W-1:0] comp_vec_type;
   typedef logic [NUM_LANES-1:0][SQ_W-1:0]   sq_vec_type;

   typedef struct packed {
      comp_vec_type comp;
      sq_vec_type   sq;
   } item_type;

   typedef struct packed {
      logic     push;
      item_type word;
   } push_type;

endpackage

@@ rtl/vector_normalize.sv @@
// Vector normaliser top level: control registers, front end, queue and arithmetic pipeline.
// Throughput: one word per cycle unless the response stalls; the square root (17 stages)
// and the four lane dividers (15 stages each) are fully pipelined, one bit per stage.
// A stalled response holds the whole arithmetic pipeline; the two-word queue lets the
// front end keep taking words until it fills. Reset is synchronous, active high, and
// clears the valid bits and the queue; dimension resets to 4 and epsilon_threshold to 1.
module vector_normalize import vn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [COMP_W-1:0]    req_comp_x,
   input  logic [COMP_W-1:0]    req_comp_y,
   input  logic [COMP_W-1:0]    req_comp_z,
   input  logic [COMP_W-1:0]    req_comp_w,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [COMP_W-1:0]    rsp_out_x,
   output logic [COMP_W-1:0]    rsp_out_y,
   output logic [COMP_W-1:0]    rsp_out_z,
   output logic [COMP_W-1:0]    rsp_out_w,
   output logic [LEN_W-1:0]     rsp_length,
   output logic                 rsp_unchanged,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   logic [DIM_W-1:0] dim_ff, dim_in;
   logic [EPS_W-1:0] eps_ff, eps_in;
   push_type         q_push;
   logic             q_full;
   logic             q_valid;
   item_type         q_word;
   logic             q_pop;

   // register writes keep the raw bits; the front end clamps the dimension
   always_comb begin
      dim_in = dim_ff;
      eps_in = eps_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIMENSION: dim_in = csr_wdata[DIM_W-1:0];
            CSR_EPSILON:   eps_in = csr_wdata[EPS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= DIM_RESET;
         eps_ff <= EPS_RESET;
      end else begin
         dim_ff <= dim_in;
         eps_ff <= eps_in;
      end
   end

   // front: take the word, zero unused lanes, square
   vn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_comp_x (req_comp_x),
      .req_comp_y (req_comp_y),
      .req_comp_z (req_comp_z),
      .req_comp_w (req_comp_w),
      .dim        (dim_ff),
      .q_full     (q_full),
      .q_push     (q_push)
   );

   // decouple the two halves
   vn_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_full  (q_full),
      .q_valid (q_valid),
      .q_word  (q_word),
      .q_pop   (q_pop)
   );

   // back: root, threshold, divide, round and saturate
   vn_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_word        (q_word),
      .q_pop         (q_pop),
      .eps           (eps_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_x     (rsp_out_x),
      .rsp_out_y     (rsp_out_y),
      .rsp_out_z     (rsp_out_z),
      .rsp_out_w     (rsp_out_w),
      .rsp_length    (rsp_length),
      .rsp_unchanged (rsp_unchanged)
   );

endmodule

@@ rtl/vn_front.sv @@
// Front end: accept a word, mask unused components and square each one.
module vn_front import vn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [COMP_W-1:0]  req_comp_x,
   input  logic [COMP_W-1:0]  req_comp_y,
   input  logic [COMP_W-1:0]  req_comp_z,
   input  logic [COMP_W-1:0]  req_comp_w,
   input  logic [DIM_W-1:0]   dim,
   input  logic               q_full,
   output push_type           q_push
);

   logic         vld_ff, vld_in;
   comp_vec_type comp_ff, comp_in;
   logic [DIM_W-1:0] eff_dim;
   logic         accept;

   always_comb begin
      priority if (dim < DIM_MIN) begin
         eff_dim = DIM_MIN;
      end else if (dim > DIM_MAX) begin
         eff_dim = DIM_MAX;
      end else begin
         eff_dim = dim;
      end
   end

   assign req_stall = vld_ff && q_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      comp_in[0] = req_comp_x;
      comp_in[1] = req_comp_y;
      comp_in[2] = (eff_dim > 3'd2) ? req_comp_z : '0;
      comp_in[3] = (eff_dim > 3'd3) ? req_comp_w : '0;
   end

   always_comb begin
      q_push.push      = vld_ff && !q_full;
      q_push.word.comp = comp_ff;
      for (int i = 0; i < NUM_LANES; i++) begin
         q_push.word.sq[i] = SQ_W'($signed(comp_ff[i]) * $signed(comp_ff[i]));
      end
   end

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (q_push.push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         comp_ff <= comp_in;
      end
   end

endmodule

@@ rtl/vn_queue.sv @@
// Two-word queue between the front end and the arithmetic pipeline.
module vn_queue import vn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type q_push,
   output logic     q_full,
   output logic     q_valid,
   output item_type q_word,
   input  logic     q_pop
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign q_full  = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_word  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = q_push.push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(q_push.push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push.push) begin
         slot_ff[wr_ptr_ff] <= q_push.word;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push.push && q_full))
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && !q_valid))
      else $error("queue read while empty");
`endif

endmodule

@@ rtl/vn_back.sv @@
// Back end: sum of squares, pipelined square root, pipelined divides, output word.
module vn_back import vn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  item_type           q_word,
   output logic               q_pop,
   input  logic [EPS_W-1:0]   eps,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [COMP_W-1:0]  rsp_out_x,
   output logic [COMP_W-1:0]  rsp_out_y,
   output logic [COMP_W-1:0]  rsp_out_z,
   output logic [COMP_W-1:0]  rsp_out_w,
   output logic [LEN_W-1:0]   rsp_length,
   output logic               rsp_unchanged
);

   localparam int RT_N   = ROOT_STAGES;
   localparam int DV_N   = QUOT_BITS;
   localparam int TERM_W = 2 * LEN_W + 2;
   localparam int DV_W   = LEN_W + 1 + DV_N + 1;
   localparam int NSTG   = RT_N + DV_N + 3;
   localparam int PREP   = RT_N + 1;
   localparam int LAST   = NSTG - 1;

   logic                         advance;
   logic [NSTG-1:0]              vld_ff, vld_in;
   comp_vec_type                 comp_ff [NSTG];
   comp_vec_type                 comp_in [NSTG];
   logic [SUM_W-1:0]             rem_ff  [RT_N+1];
   logic [SUM_W-1:0]             rem_in  [RT_N+1];
   logic [LEN_W-1:0]             root_ff [RT_N+1];
   logic [LEN_W-1:0]             root_in [RT_N+1];
   // divide stages: index 0 is the set-up stage
   logic [LEN_W-1:0]             len_ff  [DV_N+1];
   logic [LEN_W-1:0]             len_in  [DV_N+1];
   logic                         pass_ff [DV_N+1];
   logic                         pass_in [DV_N+1];
   logic [NUM_LANES-1:0]         sat_ff  [DV_N+1];
   logic [NUM_LANES-1:0]         sat_in  [DV_N+1];
   logic [NUM_LANES-1:0][DV_W-1:0]      drem_ff [DV_N+1];
   logic [NUM_LANES-1:0][DV_W-1:0]      drem_in [DV_N+1];
   logic [NUM_LANES-1:0][QUOT_BITS-1:0] quo_ff  [DV_N+1];
   logic [NUM_LANES-1:0][QUOT_BITS-1:0] quo_in  [DV_N+1];
   comp_vec_type                 res_ff, res_in;
   logic [LEN_W-1:0]             rlen_ff;
   logic                         rpass_ff;

   // the whole line moves together; hold everything while the output word waits
   assign advance = !vld_ff[LAST] || !rsp_stall;
   assign q_pop   = q_valid && advance;

   always_comb begin
      vld_in = {vld_ff[NSTG-2:0], q_pop};
      for (int s = 0; s < NSTG; s++) begin
         comp_in[s] = (s == 0) ? q_word.comp : comp_ff[(s == 0) ? 0 : s-1];
      end
   end

   // square root, one result bit a stage, remainder kept as n - root^2
   always_comb begin
      logic [TERM_W-1:0] term;
      rem_in[0]  = SUM_W'(q_word.sq[0]) + SUM_W'(q_word.sq[1])
                 + SUM_W'(q_word.sq[2]) + SUM_W'(q_word.sq[3]);
      root_in[0] = '0;
      for (int s = 1; s <= RT_N; s++) begin
         term = (TERM_W'(root_ff[s-1]) << (RT_N - s + 1))
              + (TERM_W'(1) << (2 * (RT_N - s)));
         if (TERM_W'(rem_ff[s-1]) >= term) begin
            rem_in[s]  = rem_ff[s-1] - term[SUM_W-1:0];
            root_in[s] = root_ff[s-1] | (LEN_W'(1) << (RT_N - s));
         end else begin
            rem_in[s]  = rem_ff[s-1];
            root_in[s] = root_ff[s-1];
         end
      end
   end

   // set-up: threshold test, magnitude of each component, early saturation test
   always_comb begin
      logic [COMP_W-1:0] mag;
      logic [DV_W-1:0]   num;
      logic [DV_W-1:0]   dsh;
      len_in[0]  = root_ff[RT_N];
      pass_in[0] = (root_ff[RT_N] == '0) || (root_ff[RT_N] < LEN_W'(eps));
      for (int i = 0; i < NUM_LANES; i++) begin
         mag = comp_ff[PREP-1][i][COMP_W-1] ? (~comp_ff[PREP-1][i] + 1'b1)
                                             : comp_ff[PREP-1][i];
         num = (DV_W'(mag) << DV_N) + DV_W'(root_ff[RT_N]);
         dsh = DV_W'(root_ff[RT_N]) << (DV_N + 1);
         sat_in[0][i]  = (num >= dsh);
         drem_in[0][i] = num;
         quo_in[0][i]  = '0;
      end
      for (int t = 1; t <= DV_N; t++) begin
         len_in[t]  = len_ff[t-1];
         pass_in[t] = pass_ff[t-1];
         sat_in[t]  = sat_ff[t-1];
         for (int i = 0; i < NUM_LANES; i++) begin
            dsh = DV_W'(len_ff[t-1]) << (DV_N - t + 1);
            if (drem_ff[t-1][i] >= dsh) begin
               drem_in[t][i] = drem_ff[t-1][i] - dsh;
               quo_in[t][i]  = quo_ff[t-1][i] | (QUOT_BITS'(1) << (DV_N - t));
            end else begin
               drem_in[t][i] = drem_ff[t-1][i];
               quo_in[t][i]  = quo_ff[t-1][i];
            end
         end
      end
   end

   // clamp at one, apply the sign, or pass the raw word
   always_comb begin
      logic [QUOT_BITS-1:0] qv;
      for (int i = 0; i < NUM_LANES; i++) begin
         if (sat_ff[DV_N][i] || (quo_ff[DV_N][i] > ONE_Q14)) begin
            qv = ONE_Q14;
         end else begin
            qv = quo_ff[DV_N][i];
         end
         if (pass_ff[DV_N]) begin
            res_in[i] = comp_ff[LAST-1][i];
         end else if (comp_ff[LAST-1][i][COMP_W-1]) begin
            res_in[i] = COMP_W'(0) - COMP_W'(qv);
         end else begin
            res_in[i] = COMP_W'(qv);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NSTG; s++) begin
            comp_ff[s] <= comp_in[s];
         end
         for (int s = 0; s <= RT_N; s++) begin
            rem_ff[s]  <= rem_in[s];
            root_ff[s] <= root_in[s];
         end
         for (int t = 0; t <= DV_N; t++) begin
            len_ff[t]  <= len_in[t];
            pass_ff[t] <= pass_in[t];
            sat_ff[t]  <= sat_in[t];
            drem_ff[t] <= drem_in[t];
            quo_ff[t]  <= quo_in[t];
         end
         res_ff   <= res_in;
         rlen_ff  <= len_ff[DV_N];
         rpass_ff <= pass_ff[DV_N];
      end
   end

   assign rsp_valid     = vld_ff[LAST];
   assign rsp_out_x     = res_ff[0];
   assign rsp_out_y     = res_ff[1];
   assign rsp_out_z     = res_ff[2];
   assign rsp_out_w     = res_ff[3];
   assign rsp_length    = rlen_ff;
   assign rsp_unchanged = rpass_ff;

`ifndef NO_ASSERTIONS
   a_norm_has_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_unchanged) |-> (rsp_length != '0))
      else $error("normalised word with zero length");
   a_norm_bounded: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_unchanged) |->
         ($signed(rsp_out_x) <= 16384 && $signed(rsp_out_x) >= -16384 &&
          $signed(rsp_out_w) <= 16384 && $signed(rsp_out_w) >= -16384))
      else $error("normalised component beyond one");
`endif

endmodule

@@ dv/vector_normalize_tb.sv @@
// Self-checking testbench for the vector normaliser: directed table, random words, stalls.
module vector_normalize_tb;
   import vn_pkg::*;

   typedef struct packed {
      logic [COMP_W-1:0] x, y, z, w;
      logic [LEN_W-1:0]  len;
      logic              unch;
   } norm_word_type;

   // one row of the directed table; has_gold marks a typed-in expectation
   typedef struct packed {
      logic [COMP_W-1:0] x, y, z, w;
      logic              has_gold;
      norm_word_type     gold;
   } stim_row_type;

   localparam int NUM_RANDOM = 700;
   localparam int DRAIN_CYCLES = 60;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [COMP_W-1:0]    req_comp_x = '0, req_comp_y = '0, req_comp_z = '0, req_comp_w = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [COMP_W-1:0]    rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w;
   logic [LEN_W-1:0]     rsp_length;
   logic                 rsp_unchanged;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_DIMENSION;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // predictor's own copy of the registers
   logic [DIM_W-1:0] dim_reg = DIM_RESET;
   logic [EPS_W-1:0] eps_reg = EPS_RESET;

   norm_word_type expected_words[$];
   int  fail_count = 0;
   bit  quiet_tail = 1'b0;   // no idling on either side
   bit  hold_off_req = 1'b0; // ask the receiver for a long stall

   always #6 clock = ~clock;

   vector_normalize dut (.*);

   // bitwise integer square root, floored
   function automatic logic [LEN_W-1:0] root_floor(logic [SUM_W+1:0] n);
      logic [SUM_W+1:0] res, bitv;
      res = '0;
      bitv = 35'd1 << 34;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n = n - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res[LEN_W-1:0];
   endfunction

   // Q1.14 ratio, rounded half away from zero, clamped at one
   function automatic logic [COMP_W-1:0] unit_lane(logic signed [COMP_W-1:0] c,
                                                   logic [LEN_W-1:0] len);
      logic [47:0] mag, q;
      mag = c[COMP_W-1] ? 48'(-32'(c)) : 48'(c);
      q = ((mag << 15) + 48'(len)) / (48'(len) << 1);
      if (q > 48'd16384) q = 48'd16384;
      return c[COMP_W-1] ? COMP_W'(-q) : COMP_W'(q);
   endfunction

   function automatic norm_word_type normalise(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                                               logic [COMP_W-1:0] z, logic [COMP_W-1:0] w);
      norm_word_type r;
      int d;
      logic signed [COMP_W-1:0] c[4];
      logic [SUM_W+1:0] sum;
      logic [COMP_W-1:0] o[4];
      d = (dim_reg < 2) ? 2 : (dim_reg > 4) ? 4 : int'(dim_reg);
      c[0] = x; c[1] = y; c[2] = (d > 2) ? z : '0; c[3] = (d > 3) ? w : '0;
      sum = '0;
      for (int i = 0; i < 4; i++) sum += 35'(32'(c[i]) * 32'(c[i]));
      r.len = root_floor(sum);
      r.unch = (r.len == 0) || (r.len < 17'(eps_reg));
      for (int i = 0; i < 4; i++)
         o[i] = r.unch ? c[i] : unit_lane(c[i], r.len);
      r.x = o[0]; r.y = o[1]; r.z = o[2]; r.w = o[3];
      return r;
   endfunction

   // compare each response word with the oldest expectation
   always @(posedge clock) begin
      norm_word_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_out_x, rsp_out_y, rsp_out_z, rsp_out_w, rsp_length, rsp_unchanged};
         if (expected_words.size() == 0) begin
            $display("%0t unexpected response word %h", $time, got);
            fail_count++;
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               $display("%0t mismatch: expected x=%h y=%h z=%h w=%h len=%h unch=%b",
                        $time, want.x, want.y, want.z, want.w, want.len, want.unch);
               $display("%0t            actual x=%h y=%h z=%h w=%h len=%h unch=%b",
                        $time, got.x, got.y, got.z, got.w, got.len, got.unch);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stall bursts, plus one long hold-off on request
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_stall <= 1'b1;
            repeat (200) @(posedge clock);
            hold_off_req = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 19);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one word and hold it until taken; expectation logged at acceptance
   task automatic send_word(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                            logic [COMP_W-1:0] z, logic [COMP_W-1:0] w,
                            bit has_gold, norm_word_type gold);
      int n;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_comp_x <= x; req_comp_y <= y; req_comp_z <= z; req_comp_w <= w;
      do @(posedge clock); while (req_stall);
      expected_words.push_back(has_gold ? gold : normalise(x, y, z, w));
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // write a register once the block is drained
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      while (expected_words.size() != 0) @(posedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DIMENSION) dim_reg = val[DIM_W-1:0];
      else eps_reg = val[EPS_W-1:0];
   endtask

   function automatic logic [COMP_W-1:0] rand_comp();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return COMP_W'($urandom_range(0, 15)) - 16'd8;
         default: return COMP_W'($urandom);
      endcase
   endfunction

   stim_row_type directed_rows[$];
   logic [CSR_W-1:0] eps_choices[6] = '{8'd0, 8'd1, 8'd255, 8'd16, 8'd128, 8'd3};
   logic [CSR_W-1:0] dim_choices[6] = '{8'd4, 8'd2, 8'd3, 8'd0, 8'd7, 8'd1};

   initial begin
      norm_word_type none;
      none = '0;
      // zero vector stays as is; unit axis and extremes read off at a glance
      directed_rows = '{
         '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{'0, '0, '0, '0, '0, 1'b1}},
         '{16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{16'h4000, '0, '0, '0, 17'h00100, 1'b0}},
         '{16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
           '{16'hc000, '0, '0, '0, 17'h08000, 1'b0}},
         '{16'h0000, 16'h7fff, 16'h0000, 16'h0000, 1'b1,
           '{'0, 16'h4000, '0, '0, 17'h07fff, 1'b0}},
         '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
           '{16'he000, 16'he000, 16'he000, 16'he000, 17'h10000, 1'b0}},
         '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, none},
         '{16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0, none},
         '{16'hffff, 16'h0001, 16'hffff, 16'h0001, 1'b0, none},
         '{16'h0003, 16'h0004, 16'h0000, 16'h0000, 1'b0, none},
         '{16'h0001, 16'h0001, 16'h0001, 16'h0000, 1'b0, none},
         '{16'h5555, 16'haaaa, 16'h1234, 16'hedcb, 1'b0, none}
      };
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows at reset settings, then again at the corner settings
      foreach (directed_rows[i])
         send_word(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                   directed_rows[i].w, directed_rows[i].has_gold, directed_rows[i].gold);
      drop_valid();
      repeat (DRAIN_CYCLES) @(posedge clock);
      write_csr(CSR_DIMENSION, 8'd2);
      write_csr(CSR_EPSILON, 8'd0);
      foreach (directed_rows[i])
         send_word(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                   directed_rows[i].w, 1'b0, none);
      drop_valid();

      // random phases, cycling through register settings
      for (int p = 0; p < 6; p++) begin
         write_csr(CSR_DIMENSION, dim_choices[p]);
         write_csr(CSR_EPSILON, eps_choices[p]);
         if (p == 2) hold_off_req = 1'b1;
         if (p == 5) quiet_tail = 1'b1;
         for (int k = 0; k < NUM_RANDOM / 6; k++)
            send_word(rand_comp(), rand_comp(), rand_comp(), rand_comp(), 1'b0, none);
         drop_valid();
      end

      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[vector_normalize] OK");
      else
         $display("[vector_normalize] ERROR");
      $finish;
   end

   // give up after a generous bound
   initial begin
      #2000000;
      $display("[vector_normalize] ERROR");
      $finish;
   end

endmodule
